>>> rtl/cci_pkg.sv
// Shared widths, sideband types and helpers for the circle crossing pipeline.
package cci_pkg;

  // Coordinate and derived widths
  localparam int CW    = 24;          // coordinate width, signed
  localparam int RW    = CW - 1;      // radius width, unsigned
  localparam int PW    = 2 * CW;      // square of a coordinate difference
  localparam int WW    = 2 * PW;      // radicand of the half chord
  localparam int QRW   = WW / 2;      // root width, one bit per sqrt stage
  localparam int REMW  = QRW + 4;     // sqrt partial remainder
  localparam int EW    = PW + 1;      // divisor 2*D
  localparam int CMW   = PW + 1;      // magnitude of the chord term c
  localparam int CML   = CMW - CW;    // low slice of c for the split product
  localparam int NW    = CW + CMW;    // dividend width
  localparam int CAPB  = 40;          // quotients saturate at 2^CAPB
  localparam int QW    = CAPB + 1;    // capped quotient width
  localparam int OW    = QW + 1;      // signed offset width
  localparam int SUMW  = OW + 2;      // point coordinate before clamping
  localparam int LANES = 4;
  localparam int FRONT_STAGES = 7;

  // Divider lanes
  localparam int LANE_OX = 0;
  localparam int LANE_OY = 1;
  localparam int LANE_UX = 2;
  localparam int LANE_UY = 3;

  // Sideband carried alongside the square root
  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic [CW-1:0]        ax;
    logic [CW-1:0]        ay;
    logic                 nx;
    logic                 ny;
    logic                 cneg;
    logic [EW-1:0]        e;
    logic [NW-1:0]        n_ox;
    logic [NW-1:0]        n_oy;
  } sq_side_t;

  // Sideband carried alongside the dividers
  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic [LANES-1:0]     neg;
  } dv_side_t;

  // Clamp a wide point coordinate to the signed coordinate range
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUMW-1:0] v);
    logic [SUMW-CW:0] top;
    top = v[SUMW-1:CW-1];
    if (top == '0 || top == '1) begin
      return $signed(v[CW-1:0]);
    end else if (v[SUMW-1]) begin
      return $signed({1'b1, {(CW-1){1'b0}}});
    end else begin
      return $signed({1'b0, {(CW-1){1'b1}}});
    end
  endfunction

endpackage

>>> rtl/circle_circle_intersection_core.sv
// Top level: circle-circle crossing points, fully pipelined.
//
// A request carries two circles (signed Q12.12 centers, unsigned Q11.12
// radii) and is taken at a rising edge where start is high and busy is low.
// busy is always low: the pipeline takes one request every clock cycle.
// Each request yields exactly one result, shown for one cycle with done_o
// high, in request order. hit_o is high when the outlines cross at two
// distinct points; the two points then sit on start_x_o/start_y_o and
// end_x_o/end_y_o, otherwise those fields are zero. A request passes
// through 101 register stages, the first loaded at the taking edge: 7
// front stages, 48 square-root stages (one root bit each), 2 dividend
// stages, 41 divider stages (cap test plus one quotient bit each) and 3
// output stages. Reset clears all valid bits; requests in flight are
// dropped and no result appears until a new request arrives. The receiver
// must take a result in the cycle it is shown; there is no hold-off.
module circle_circle_intersection_core import cci_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] first_center_x_i,
  input  logic signed [CW-1:0] first_center_y_i,
  input  logic [RW-1:0]        first_radius_i,
  input  logic signed [CW-1:0] second_center_x_i,
  input  logic signed [CW-1:0] second_center_y_i,
  input  logic [RW-1:0]        second_radius_i,
  output logic                 done_o,
  output logic                 hit_o,
  output logic signed [CW-1:0] start_x_o,
  output logic signed [CW-1:0] start_y_o,
  output logic signed [CW-1:0] end_x_o,
  output logic signed [CW-1:0] end_y_o
);

  logic                     fr_valid, sq_valid, pr_valid, dv_valid;
  logic [WW-1:0]            fr_w;
  sq_side_t                 fr_side, sq_side;
  logic [QRW-1:0]           sq_root;
  logic [LANES-1:0][NW-1:0] pr_num;
  logic [EW-1:0]            pr_e;
  dv_side_t                 pr_side, dv_side;
  logic [LANES-1:0][QW-1:0] dv_quo;

  assign busy = 1'b0;

  cci_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .x1_i    (first_center_x_i),
    .y1_i    (first_center_y_i),
    .r1_i    (first_radius_i),
    .x2_i    (second_center_x_i),
    .y2_i    (second_center_y_i),
    .r2_i    (second_radius_i),
    .valid_o (fr_valid),
    .w_o     (fr_w),
    .side_o  (fr_side)
  );

  cci_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .w_i     (fr_w),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  cci_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .side_i  (sq_side),
    .valid_o (pr_valid),
    .num_o   (pr_num),
    .e_o     (pr_e),
    .side_o  (pr_side)
  );

  cci_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pr_valid),
    .num_i   (pr_num),
    .e_i     (pr_e),
    .side_i  (pr_side),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  cci_post u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (dv_valid),
    .quo_i     (dv_quo),
    .side_i    (dv_side),
    .done_o    (done_o),
    .hit_o     (hit_o),
    .start_x_o (start_x_o),
    .start_y_o (start_y_o),
    .end_x_o   (end_x_o),
    .end_y_o   (end_y_o)
  );

  // A hit always leaves a nonzero divisor behind the square root
  a_hit_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid && sq_side.hit |-> sq_side.e != '0)
    else $error("hit with zero divisor");

  // A miss shows all point fields as zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> start_x_o == '0 && start_y_o == '0 &&
                         end_x_o == '0 && end_y_o == '0)
    else $error("miss with nonzero point");

  // A hit never reports two equal points
  a_hit_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_o |-> start_x_o != end_x_o || start_y_o != end_y_o)
    else $error("hit with collapsed points");

endmodule

>>> rtl/cci_front.sv
// Front stages: center deltas, squares, hit test, radicand and chord dividends.
module cci_front import cci_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] x1_i,
  input  logic signed [CW-1:0] y1_i,
  input  logic [RW-1:0]        r1_i,
  input  logic signed [CW-1:0] x2_i,
  input  logic signed [CW-1:0] y2_i,
  input  logic [RW-1:0]        r2_i,
  output logic                 valid_o,
  output logic [WW-1:0]        w_o,
  output sq_side_t             side_o
);

  logic [FRONT_STAGES-1:0] v_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[FRONT_STAGES-2:0], valid_i};
    end
  end

  // Stage 1: deltas, radius sum and difference
  logic signed [CW:0] dx_d, dy_d;
  logic [CW:0]        ax1_q, ay1_q;
  logic               nx1_q, ny1_q;
  logic [CW-1:0]      s1_q;
  logic [RW-1:0]      m1_q, r11_q, r21_q;
  logic signed [CW-1:0] x11_q, y11_q;

  assign dx_d = {x2_i[CW-1], x2_i} - {x1_i[CW-1], x1_i};
  assign dy_d = {y2_i[CW-1], y2_i} - {y1_i[CW-1], y1_i};

  always_ff @(posedge clk_i) begin
    ax1_q <= dx_d[CW] ? -dx_d : dx_d;
    ay1_q <= dy_d[CW] ? -dy_d : dy_d;
    nx1_q <= dx_d[CW];
    ny1_q <= dy_d[CW];
    s1_q  <= {1'b0, r1_i} + {1'b0, r2_i};
    m1_q  <= (r1_i > r2_i) ? r1_i - r2_i : r2_i - r1_i;
    r11_q <= r1_i;
    r21_q <= r2_i;
    x11_q <= x1_i;
    y11_q <= y1_i;
  end

  // Stage 2: squares and far test
  logic          far2_q, nx2_q, ny2_q;
  logic [CW-1:0] ax2_q, ay2_q;
  logic [PW-1:0] ss2_q, mm2_q, xx2_q, yy2_q, r1s2_q, r2s2_q;
  logic signed [CW-1:0] x12_q, y12_q;

  always_ff @(posedge clk_i) begin
    far2_q <= (ax1_q > {1'b0, s1_q}) || (ay1_q > {1'b0, s1_q});
    ss2_q  <= s1_q * s1_q;
    mm2_q  <= PW'(m1_q * m1_q);
    xx2_q  <= ax1_q[CW-1:0] * ax1_q[CW-1:0];
    yy2_q  <= ay1_q[CW-1:0] * ay1_q[CW-1:0];
    r1s2_q <= PW'(r11_q * r11_q);
    r2s2_q <= PW'(r21_q * r21_q);
    ax2_q  <= ax1_q[CW-1:0];
    ay2_q  <= ay1_q[CW-1:0];
    nx2_q  <= nx1_q;
    ny2_q  <= ny1_q;
    x12_q  <= x11_q;
    y12_q  <= y11_q;
  end

  // Stage 3: squared distance and radius-square difference
  logic [PW:0]        dd3_q;
  logic signed [PW:0] dr3_q;
  logic [PW-1:0]      ss3_q, mm3_q;
  logic               far3_q, nx3_q, ny3_q;
  logic [CW-1:0]      ax3_q, ay3_q;
  logic signed [CW-1:0] x13_q, y13_q;

  always_ff @(posedge clk_i) begin
    dd3_q  <= {1'b0, xx2_q} + {1'b0, yy2_q};
    dr3_q  <= $signed({1'b0, r1s2_q}) - $signed({1'b0, r2s2_q});
    ss3_q  <= ss2_q;
    mm3_q  <= mm2_q;
    far3_q <= far2_q;
    ax3_q  <= ax2_q;
    ay3_q  <= ay2_q;
    nx3_q  <= nx2_q;
    ny3_q  <= ny2_q;
    x13_q  <= x12_q;
    y13_q  <= y12_q;
  end

  // Stage 4: hit window, radicand factors, signed chord term
  logic               hit4_q, nx4_q, ny4_q;
  logic [PW-1:0]      a4_q, b4_q;
  logic [PW+1:0]      c4_q;
  logic [EW-1:0]      e4_q;
  logic [CW-1:0]      ax4_q, ay4_q;
  logic signed [CW-1:0] x14_q, y14_q;

  always_ff @(posedge clk_i) begin
    hit4_q <= !far3_q && (dd3_q < {1'b0, ss3_q}) && (dd3_q > {1'b0, mm3_q});
    a4_q   <= ss3_q - dd3_q[PW-1:0];
    b4_q   <= dd3_q[PW-1:0] - mm3_q;
    c4_q   <= {1'b0, dd3_q} + {dr3_q[PW], dr3_q};
    e4_q   <= {dd3_q[PW-1:0], 1'b0};
    ax4_q  <= ax3_q;
    ay4_q  <= ay3_q;
    nx4_q  <= nx3_q;
    ny4_q  <= ny3_q;
    x14_q  <= x13_q;
    y14_q  <= y13_q;
  end

  // Stage 5: chord magnitude, radicand partial products
  logic               hit5_q, nx5_q, ny5_q, cneg5_q;
  logic [CMW-1:0]     cm5_q;
  logic [PW-1:0]      whh5_q, whl5_q, wlh5_q, wll5_q;
  logic [EW-1:0]      e5_q;
  logic [CW-1:0]      ax5_q, ay5_q;
  logic signed [CW-1:0] x15_q, y15_q;

  always_ff @(posedge clk_i) begin
    cneg5_q <= c4_q[PW+1];
    cm5_q   <= c4_q[PW+1] ? CMW'(~c4_q + 1'b1) : CMW'(c4_q);
    whh5_q  <= a4_q[PW-1:CW] * b4_q[PW-1:CW];
    whl5_q  <= a4_q[PW-1:CW] * b4_q[CW-1:0];
    wlh5_q  <= a4_q[CW-1:0] * b4_q[PW-1:CW];
    wll5_q  <= a4_q[CW-1:0] * b4_q[CW-1:0];
    hit5_q  <= hit4_q;
    e5_q    <= e4_q;
    ax5_q   <= ax4_q;
    ay5_q   <= ay4_q;
    nx5_q   <= nx4_q;
    ny5_q   <= ny4_q;
    x15_q   <= x14_q;
    y15_q   <= y14_q;
  end

  // Stage 6: sum radicand, chord dividend partial products
  logic [PW:0]        mid_d;
  logic [WW-1:0]      w6_q;
  logic [CMW-1:0]     pxl6_q, pyl6_q;
  logic [PW-1:0]      pxh6_q, pyh6_q;
  logic               hit6_q, nx6_q, ny6_q, cneg6_q;
  logic [EW-1:0]      e6_q;
  logic [CW-1:0]      ax6_q, ay6_q;
  logic signed [CW-1:0] x16_q, y16_q;

  assign mid_d = {1'b0, whl5_q} + {1'b0, wlh5_q};

  always_ff @(posedge clk_i) begin
    w6_q    <= {whh5_q, wll5_q} + (WW'(mid_d) << CW);
    pxl6_q  <= ax5_q * cm5_q[CML-1:0];
    pxh6_q  <= ax5_q * cm5_q[CMW-1:CML];
    pyl6_q  <= ay5_q * cm5_q[CML-1:0];
    pyh6_q  <= ay5_q * cm5_q[CMW-1:CML];
    hit6_q  <= hit5_q;
    cneg6_q <= cneg5_q;
    e6_q    <= e5_q;
    ax6_q   <= ax5_q;
    ay6_q   <= ay5_q;
    nx6_q   <= nx5_q;
    ny6_q   <= ny5_q;
    x16_q   <= x15_q;
    y16_q   <= y15_q;
  end

  // Stage 7: sum chord dividends
  logic [WW-1:0] w7_q;
  sq_side_t      side7_q;

  always_ff @(posedge clk_i) begin
    w7_q         <= w6_q;
    side7_q.hit  <= hit6_q;
    side7_q.x1   <= x16_q;
    side7_q.y1   <= y16_q;
    side7_q.ax   <= ax6_q;
    side7_q.ay   <= ay6_q;
    side7_q.nx   <= nx6_q;
    side7_q.ny   <= ny6_q;
    side7_q.cneg <= cneg6_q;
    side7_q.e    <= e6_q;
    side7_q.n_ox <= (NW'(pxh6_q) << CML) + NW'(pxl6_q);
    side7_q.n_oy <= (NW'(pyh6_q) << CML) + NW'(pyl6_q);
  end

  assign valid_o = v_q[FRONT_STAGES-1];
  assign w_o     = w7_q;
  assign side_o  = side7_q;

endmodule

>>> rtl/cci_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
module cci_sqrt import cci_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [WW-1:0]  w_i,
  input  sq_side_t       side_i,
  output logic           valid_o,
  output logic [QRW-1:0] root_o,
  output sq_side_t       side_o
);

  logic            v_q    [1:QRW];
  logic [WW-1:0]   w_q    [1:QRW];
  logic [REMW-1:0] rem_q  [1:QRW];
  logic [QRW-1:0]  root_q [1:QRW];
  sq_side_t        side_q [1:QRW];

  for (genvar g = 0; g < QRW; g++) begin : g_stage
    logic            pv;
    logic [WW-1:0]   pw;
    logic [REMW-1:0] prem, rem_t, trial;
    logic [QRW-1:0]  proot;
    sq_side_t        pside;
    logic            ge;

    if (g == 0) begin : g_first
      assign pv    = valid_i;
      assign pw    = w_i;
      assign prem  = '0;
      assign proot = '0;
      assign pside = side_i;
    end else begin : g_next
      assign pv    = v_q[g];
      assign pw    = w_q[g];
      assign prem  = rem_q[g];
      assign proot = root_q[g];
      assign pside = side_q[g];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem_t = {prem[REMW-3:0], pw[WW-1:WW-2]};
    assign trial = {2'b00, proot, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= 1'b0;
      end else begin
        v_q[g+1] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      w_q[g+1]    <= {pw[WW-3:0], 2'b00};
      rem_q[g+1]  <= ge ? rem_t - trial : rem_t;
      root_q[g+1] <= {proot[QRW-2:0], ge};
      side_q[g+1] <= pside;
    end
  end

  assign valid_o = v_q[QRW];
  assign root_o  = root_q[QRW];
  assign side_o  = side_q[QRW];

endmodule

>>> rtl/cci_prep.sv
// Half-chord dividends from the root and lane setup for the dividers.
module cci_prep import cci_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [QRW-1:0]             root_i,
  input  sq_side_t                   side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][NW-1:0]   num_o,
  output logic [EW-1:0]              e_o,
  output dv_side_t                   side_o
);

  localparam int RH = QRW - CW;

  logic [1:0] v_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[0], valid_i};
    end
  end

  // Stage 1: partial products of the root
  logic [CW+RH-1:0] ayh1_q, axh1_q;
  logic [PW-1:0]    ayl1_q, axl1_q;
  sq_side_t         side1_q;

  always_ff @(posedge clk_i) begin
    ayl1_q  <= side_i.ay * root_i[CW-1:0];
    ayh1_q  <= side_i.ay * root_i[QRW-1:CW];
    axl1_q  <= side_i.ax * root_i[CW-1:0];
    axh1_q  <= side_i.ax * root_i[QRW-1:CW];
    side1_q <= side_i;
  end

  // Stage 2: sum dividends, set lane signs
  logic [LANES-1:0][NW-1:0] num2_q;
  logic [EW-1:0]            e2_q;
  dv_side_t                 side2_q;

  always_ff @(posedge clk_i) begin
    num2_q[LANE_OX] <= side1_q.n_ox;
    num2_q[LANE_OY] <= side1_q.n_oy;
    num2_q[LANE_UX] <= (NW'(ayh1_q) << CW) + NW'(ayl1_q);
    num2_q[LANE_UY] <= (NW'(axh1_q) << CW) + NW'(axl1_q);
    e2_q            <= side1_q.e;
    side2_q.hit     <= side1_q.hit;
    side2_q.x1      <= side1_q.x1;
    side2_q.y1      <= side1_q.y1;
    side2_q.neg[LANE_OX] <= side1_q.nx ^ side1_q.cneg;
    side2_q.neg[LANE_OY] <= side1_q.ny ^ side1_q.cneg;
    side2_q.neg[LANE_UX] <= side1_q.ny;
    side2_q.neg[LANE_UY] <= side1_q.nx;
  end

  assign valid_o = v_q[1];
  assign num_o   = num2_q;
  assign e_o     = e2_q;
  assign side_o  = side2_q;

endmodule

>>> rtl/cci_div.sv
// Four-lane pipelined restoring divider, quotient floor(n / e) capped at 2^CAPB.
module cci_div import cci_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [LANES-1:0][NW-1:0] num_i,
  input  logic [EW-1:0]            e_i,
  input  dv_side_t                 side_i,
  output logic                     valid_o,
  output logic [LANES-1:0][QW-1:0] quo_o,
  output dv_side_t                 side_o
);

  logic                        v_q    [0:CAPB];
  logic [LANES-1:0]            ovf_q  [0:CAPB];
  logic [LANES-1:0][EW-1:0]    rem_q  [0:CAPB];
  logic [LANES-1:0][CAPB-1:0]  lo_q   [0:CAPB];
  logic [LANES-1:0][CAPB-1:0]  quo_q  [0:CAPB];
  logic [EW-1:0]               e_q    [0:CAPB];
  dv_side_t                    side_q [0:CAPB];

  for (genvar g = 0; g <= CAPB; g++) begin : g_stage
    logic [LANES-1:0]           ovf_d;
    logic [LANES-1:0][EW-1:0]   rem_d;
    logic [LANES-1:0][CAPB-1:0] lo_d, quo_d;

    if (g == 0) begin : g_first
      // Cap test on the top dividend bits, which also seed the remainder
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign ovf_d[l] = EW'(num_i[l][NW-1:CAPB]) >= e_i;
        assign rem_d[l] = EW'(num_i[l][NW-1:CAPB]);
        assign lo_d[l]  = num_i[l][CAPB-1:0];
        assign quo_d[l] = '0;
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[0] <= 1'b0;
        end else begin
          v_q[0] <= valid_i;
        end
      end

      always_ff @(posedge clk_i) begin
        e_q[0]    <= e_i;
        side_q[0] <= side_i;
      end
    end else begin : g_next
      // Shift in one dividend bit, subtract when it fits
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [EW:0] t;
        logic        ge;
        assign t        = {rem_q[g-1][l], lo_q[g-1][l][CAPB-1]};
        assign ge       = t >= {1'b0, e_q[g-1]};
        assign ovf_d[l] = ovf_q[g-1][l];
        assign rem_d[l] = ge ? EW'(t - {1'b0, e_q[g-1]}) : t[EW-1:0];
        assign lo_d[l]  = {lo_q[g-1][l][CAPB-2:0], 1'b0};
        assign quo_d[l] = {quo_q[g-1][l][CAPB-2:0], ge};
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[g] <= 1'b0;
        end else begin
          v_q[g] <= v_q[g-1];
        end
      end

      always_ff @(posedge clk_i) begin
        e_q[g]    <= e_q[g-1];
        side_q[g] <= side_q[g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      ovf_q[g] <= ovf_d;
      rem_q[g] <= rem_d;
      lo_q[g]  <= lo_d;
      quo_q[g] <= quo_d;
    end
  end

  // Apply the cap
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_o[l] = ovf_q[CAPB][l] ? {1'b1, {CAPB{1'b0}}} : {1'b0, quo_q[CAPB][l]};
  end

  assign valid_o = v_q[CAPB];
  assign side_o  = side_q[CAPB];

endmodule

>>> rtl/cci_post.sv
// Final stages: signed offsets, point sums, clamping and collapse test.
module cci_post import cci_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [LANES-1:0][QW-1:0] quo_i,
  input  dv_side_t                 side_i,
  output logic                     done_o,
  output logic                     hit_o,
  output logic signed [CW-1:0]     start_x_o,
  output logic signed [CW-1:0]     start_y_o,
  output logic signed [CW-1:0]     end_x_o,
  output logic signed [CW-1:0]     end_y_o
);

  logic [1:0] v_q;
  logic       done_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_q <= 1'b0;
    end else begin
      v_q    <= {v_q[0], valid_i};
      done_q <= v_q[1];
    end
  end

  // Stage 1: sign the quotients, add the first center
  logic signed [OW-1:0] off_d [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_sign
    logic signed [OW-1:0] mag;
    assign mag      = $signed(OW'(quo_i[l]));
    assign off_d[l] = side_i.neg[l] ? -mag : mag;
  end

  logic signed [SUMW-1:0] px1_q, py1_q;
  logic signed [OW-1:0]   ux1_q, uy1_q;
  logic                   hit1_q;

  always_ff @(posedge clk_i) begin
    px1_q  <= SUMW'(side_i.x1) + SUMW'(off_d[LANE_OX]);
    py1_q  <= SUMW'(side_i.y1) + SUMW'(off_d[LANE_OY]);
    ux1_q  <= off_d[LANE_UX];
    uy1_q  <= off_d[LANE_UY];
    hit1_q <= side_i.hit;
  end

  // Stage 2: both points, clamped
  logic signed [CW-1:0] sx2_q, sy2_q, ex2_q, ey2_q;
  logic                 hit2_q;

  always_ff @(posedge clk_i) begin
    sx2_q  <= sat_coord(px1_q - SUMW'(ux1_q));
    sy2_q  <= sat_coord(py1_q + SUMW'(uy1_q));
    ex2_q  <= sat_coord(px1_q + SUMW'(ux1_q));
    ey2_q  <= sat_coord(py1_q - SUMW'(uy1_q));
    hit2_q <= hit1_q;
  end

  // Stage 3: drop collapsed points, zero the fields on a miss
  logic                 hit_d;
  logic                 hit3_q;
  logic signed [CW-1:0] sx3_q, sy3_q, ex3_q, ey3_q;

  assign hit_d = hit2_q && !((sx2_q == ex2_q) && (sy2_q == ey2_q));

  always_ff @(posedge clk_i) begin
    hit3_q <= hit_d;
    sx3_q  <= hit_d ? sx2_q : '0;
    sy3_q  <= hit_d ? sy2_q : '0;
    ex3_q  <= hit_d ? ex2_q : '0;
    ey3_q  <= hit_d ? ey2_q : '0;
  end

  assign done_o    = done_q;
  assign hit_o     = hit3_q;
  assign start_x_o = sx3_q;
  assign start_y_o = sy3_q;
  assign end_x_o   = ex3_q;
  assign end_y_o   = ey3_q;

endmodule

>>> tb/tb_top.sv
// Testbench for the circle-circle crossing pipeline: directed and random requests.
module tb_top;
  import cci_pkg::*;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
  } crossing_t;

  localparam longint LIMIT_CYCLES = 200000;
  localparam longint CAP = longint'(1) << CAPB;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CW-1:0] fcx = '0, fcy = '0, scx = '0, scy = '0;
  logic [RW-1:0]        fr = '0, sr = '0;
  logic                 done_o, hit_o;
  logic signed [CW-1:0] start_x_o, start_y_o, end_x_o, end_y_o;

  // Ring of predictions still waiting for their result
  crossing_t crossings_due [0:1023];
  logic [9:0] due_wr = '0;
  logic [9:0] due_rd = '0;
  int        fail_count = 0;
  longint    cycle_count = 0;

  circle_circle_intersection_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .first_center_x_i(fcx), .first_center_y_i(fcy), .first_radius_i(fr),
    .second_center_x_i(scx), .second_center_y_i(scy), .second_radius_i(sr),
    .done_o(done_o), .hit_o(hit_o), .start_x_o(start_x_o), .start_y_o(start_y_o),
    .end_x_o(end_x_o), .end_y_o(end_y_o)
  );

  always #2 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  // Truncated quotient a*b/(2d) with sign, capped at 2^40
  function automatic longint chord_quot(input logic [127:0] prod, input logic neg,
                                        input logic [127:0] d);
    logic [127:0] q;
    longint m;
    q = prod / (d << 1);
    m = (q > CAP) ? CAP : longint'(q);
    return neg ? -m : m;
  endfunction

  function automatic longint clamp_coord(input longint v);
    longint hi, lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -(longint'(1) << (CW - 1));
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic logic [63:0] isqrt(input logic [127:0] n);
    logic [63:0] root, cand;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (128'(cand) * 128'(cand) <= n) root = cand;
    end
    return root;
  endfunction

  // Predict the crossing points of one request
  function automatic crossing_t predict_crossing(
      input logic signed [CW-1:0] x1, y1, x2, y2, input logic [RW-1:0] r1, r2);
    crossing_t res;
    longint dx, dy, ax, ay, s, m, sx, sy, ex, ey, ox, oy, ux, uy;
    logic [127:0] dd, ss, mm, r1s, r2s, cm, root;
    logic cneg;
    res = '0;
    dx = longint'(x2) - longint'(x1);
    dy = longint'(y2) - longint'(y1);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    s = longint'(r1) + longint'(r2);
    m = r1 > r2 ? longint'(r1) - longint'(r2) : longint'(r2) - longint'(r1);
    dd = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
    ss = 128'(s) * 128'(s);
    mm = 128'(m) * 128'(m);
    if (dd >= ss || dd <= mm) return res;
    root = 128'(isqrt((ss - dd) * (dd - mm)));
    r1s = 128'(r1) * 128'(r1);
    r2s = 128'(r2) * 128'(r2);
    if (r1s >= r2s) begin
      cm = dd + r1s - r2s; cneg = 1'b0;
    end else if (dd >= r2s - r1s) begin
      cm = dd - (r2s - r1s); cneg = 1'b0;
    end else begin
      cm = r2s - r1s - dd; cneg = 1'b1;
    end
    ox = chord_quot(128'(ax) * cm, (dx < 0) != cneg, dd);
    oy = chord_quot(128'(ay) * cm, (dy < 0) != cneg, dd);
    ux = chord_quot(128'(ay) * root, dy < 0, dd);
    uy = chord_quot(128'(ax) * root, dx < 0, dd);
    sx = clamp_coord(longint'(x1) + ox - ux);
    sy = clamp_coord(longint'(y1) + oy + uy);
    ex = clamp_coord(longint'(x1) + ox + ux);
    ey = clamp_coord(longint'(y1) + oy - uy);
    if (sx == ex && sy == ey) return res;
    res.hit = 1'b1;
    res.sx = sx[CW-1:0]; res.sy = sy[CW-1:0];
    res.ex = ex[CW-1:0]; res.ey = ey[CW-1:0];
    return res;
  endfunction

  // Send one request, after a gap given by the caller
  task automatic send_circles(input logic signed [CW-1:0] x1, y1, input logic [RW-1:0] r1,
                              input logic signed [CW-1:0] x2, y2, input logic [RW-1:0] r2,
                              input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    fcx <= x1; fcy <= y1; fr <= r1; scx <= x2; scy <= y2; sr <= r2;
    do @(posedge clk_i); while (busy);
    crossings_due[due_wr] = predict_crossing(x1, y1, x2, y2, r1, r2);
    due_wr = due_wr + 10'd1;
    @(negedge clk_i);
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  // Check each result against the oldest prediction
  always @(posedge clk_i) begin
    crossing_t exp_c;
    if (rst_ni && done_o) begin
      if (due_rd == due_wr) begin
        report_mismatch("result with no request outstanding");
      end else begin
        exp_c = crossings_due[due_rd];
        due_rd = due_rd + 10'd1;
        if (hit_o !== exp_c.hit)
          report_mismatch($sformatf("hit %b exp %b", hit_o, exp_c.hit));
        if (start_x_o !== exp_c.sx)
          report_mismatch($sformatf("start_x %0d exp %0d", start_x_o, exp_c.sx));
        if (start_y_o !== exp_c.sy)
          report_mismatch($sformatf("start_y %0d exp %0d", start_y_o, exp_c.sy));
        if (end_x_o !== exp_c.ex)
          report_mismatch($sformatf("end_x %0d exp %0d", end_x_o, exp_c.ex));
        if (end_y_o !== exp_c.ey)
          report_mismatch($sformatf("end_y %0d exp %0d", end_y_o, exp_c.ey));
      end
    end
  end

  localparam logic signed [CW-1:0] CMAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMINV = {1'b1, {(CW-1){1'b0}}};
  localparam logic [RW-1:0]        RMAXV = '1;

  // Cover the special cases one by one
  task automatic test_directed();
    // plain crossing
    send_circles(24'sd0, 24'sd0, 23'd4096, 24'sd4096, 24'sd0, 23'd4096, 0);
    // separated
    send_circles(24'sd0, 24'sd0, 23'd4096, 24'sd16384, 24'sd0, 23'd4096, 0);
    // outer tangent
    send_circles(24'sd0, 24'sd0, 23'd4096, 24'sd8192, 24'sd0, 23'd4096, 0);
    // one inside the other
    send_circles(24'sd0, 24'sd0, 23'd16384, 24'sd1000, 24'sd0, 23'd1000, 0);
    // inner tangent
    send_circles(24'sd0, 24'sd0, 23'd8192, 24'sd4096, 24'sd0, 23'd4096, 0);
    // identical
    send_circles(24'sd500, -24'sd700, 23'd3000, 24'sd500, -24'sd700, 23'd3000, 0);
    // tiny, collapsing
    send_circles(24'sd0, 24'sd0, 23'd5, 24'sd3, 24'sd4, 23'd2, 0);
    send_circles(24'sd0, 24'sd0, 23'd1, 24'sd1, 24'sd0, 23'd1, 0);
    // saturation high and low
    send_circles(CMAXV, CMAXV, RMAXV, CMAXV - 24'sd4096, CMAXV, RMAXV, 0);
    send_circles(CMINV, CMINV, RMAXV, CMINV + 24'sd4096, CMINV, RMAXV, 0);
    // widest offsets
    send_circles(CMINV, CMINV, RMAXV, CMAXV, CMAXV, RMAXV, 0);
    send_circles(CMAXV, CMINV, RMAXV, CMINV, CMAXV, RMAXV, 0);
    send_circles(CMINV, 24'sd0, 23'd0, CMAXV, 24'sd0, RMAXV, 0);
    send_circles(24'sd0, 24'sd0, RMAXV, 24'sd1, 24'sd1, RMAXV, 0);
    send_circles(-24'sd4096, 24'sd2048, 23'd3000, 24'sd2048, -24'sd4096, 23'd6000, 0);
    send_circles(24'sd0, 24'sd0, 23'd0, 24'sd0, 24'sd0, 23'd0, 0);
  endtask

  // Random pairs, mostly ones that overlap near the crossing range
  task automatic test_random(input int count);
    logic signed [CW-1:0] x1, y1, x2, y2;
    logic [RW-1:0] r1, r2;
    int sh;
    for (int i = 0; i < count; i++) begin
      sh = $urandom_range(4, 22);
      x1 = CW'($urandom); y1 = CW'($urandom);
      r1 = RW'($urandom_range(0, (1 << sh) - 1));
      r2 = RW'($urandom_range(0, (1 << sh) - 1));
      if ($urandom_range(0, 4) != 0) begin
        x2 = x1 + $signed(24'($urandom_range(0, 2 << sh)) - 24'(1 << sh));
        y2 = y1 + $signed(24'($urandom_range(0, 2 << sh)) - 24'(1 << sh));
      end else begin
        x2 = CW'($urandom); y2 = CW'($urandom);
        r1 = RW'($urandom); r2 = RW'($urandom);
      end
      send_circles(x1, y1, r1, x2, y2, r2, (i % 100 < 40) ? 0 : pick_gap());
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(550);
    start <= 1'b0;
    while (due_rd != due_wr) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
